// ----- design/bfc8_pkg.sv -----
// Shared types, register codes and helper functions for the button frame
// CRC-8 serializer. Used by button_frame_crc8_serializer_core; no dependencies.
package bfc8_pkg;

  // Serializer sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_e;

  // Configuration register indexes.
  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_COMMAND = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_RESET  = 8'hA5;
  localparam logic [7:0] COMMAND_RESET = 8'h04;

  // CRC-8 on the Dallas/Maxim polynomial: reflected polynomial and initial value.
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [7:0] CRC_INIT      = 8'hFF;

  // One byte of the reflected CRC: eight shift and conditional xor steps.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Scatter the button sample into frame bytes 2, 3 and 4 (byte 2 lowest).
  function automatic logic [23:0] pack_buttons(input logic [13:0] b);
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    b2 = {b[11], b[8], b[10], b[9], 4'b0000};
    b3 = {b[7], b[0], b[2], b[1], b[12], b[5], b[3], b[13]};
    b4 = {4'b0000, b[4], b[6], 2'b00};
    return {b4, b3, b2};
  endfunction

endpackage

// ----- design/button_frame_crc8_serializer_core.sv -----
// Top level of the button frame serializer: takes a button sample and streams
// a framed packet with a CRC-8 trailer. Depends on bfc8_pkg.

// One button sample on the slave stream becomes a frame of FRAME_BYTES bytes on
// the master stream, one byte per beat: header, command, three bytes of button
// bits, zero padding, and a reflected CRC-8 (poly 0x31, init 0xFF) flagged with
// tlast. The frame leaves through a 32-bit shift register that moves one byte
// per beat, while the CRC is folded in one byte per beat. A new sample is
// taken only once the last beat of the current frame has been accepted. The
// header and command registers are to be written through the cfg port only
// while no frame is in flight; the block itself does not enforce this.
module button_frame_crc8_serializer_core #(
  parameter int FRAME_BYTES = 33
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // Slave stream: button samples.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [13:0] button_bits, [15:14] zero
  // Master stream: frame bytes.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] frame_byte
  output logic        m_axis_tlast_o    // frame_last
);

  localparam int CntW = $clog2(FRAME_BYTES);
  localparam logic [CntW-1:0] CrcIdx = CntW'(FRAME_BYTES - 2);

  // Configuration registers.
  logic [7:0] header_q;
  logic [7:0] command_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= bfc8_pkg::HEADER_RESET;
      command_q <= bfc8_pkg::COMMAND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfc8_pkg::REG_HEADER:  header_q  <= cfg_wdata_i;
        bfc8_pkg::REG_COMMAND: command_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  bfc8_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       byte_q, byte_d;
  logic [31:0]      sh_q, sh_d;
  logic [7:0]       crc_q, crc_d;
  logic             last_q, last_d;

  logic in_fire;
  logic out_fire;
  logic [7:0] crc_next;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign crc_next = bfc8_pkg::crc8_update(crc_q, byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfc8_pkg::ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      crc_q   <= bfc8_pkg::CRC_INIT;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      crc_q   <= crc_d;
    end
  end

  // Payload shift register and presented byte.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    sh_q   <= sh_d;
  end

  // Next state: load a sample, then shift out one byte per accepted beat.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    byte_d  = byte_q;
    sh_d    = sh_q;
    crc_d   = crc_q;
    last_d  = last_q;
    case (state_q)
      bfc8_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = bfc8_pkg::ST_SEND;
          cnt_d   = '0;
          byte_d  = header_q;
          sh_d    = {bfc8_pkg::pack_buttons(s_axis_tdata_i[13:0]), command_q};
          crc_d   = bfc8_pkg::CRC_INIT;
          last_d  = 1'b0;
        end
      end
      bfc8_pkg::ST_SEND: begin
        if (out_fire) begin
          if (last_q) begin
            state_d = bfc8_pkg::ST_IDLE;
            last_d  = 1'b0;
          end else begin
            crc_d = crc_next;
            cnt_d = cnt_q + 1'b1;
            sh_d  = {8'h00, sh_q[31:8]};
            if (cnt_q == CrcIdx) begin
              byte_d = crc_next;
              last_d = 1'b1;
            end else begin
              byte_d = sh_q[7:0];
            end
          end
        end
      end
      default: state_d = bfc8_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == bfc8_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == bfc8_pkg::ST_SEND);
  assign m_axis_tdata_o  = byte_q;
  assign m_axis_tlast_o  = last_q;

`ifndef SYNTHESIS
  // The trailer is flagged only at the final byte position of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast_o |-> (cnt_q == CntW'(FRAME_BYTES - 1)))
    else $error("tlast away from the final frame byte");

  // After the trailer beat is taken the block is ready for a new sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast_o) |=> (s_axis_tready_o && !m_axis_tvalid_o))
    else $error("not idle after frame end");

  // An accepted sample starts a frame with the header beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (m_axis_tvalid_o && !m_axis_tlast_o && (m_axis_tdata_o == $past(header_q))))
    else $error("frame did not start with header");
`endif

endmodule
